[hw/rtl/lsam_pkg.sv]
// ----------------------------------------------------------------------------
// lsam_pkg
// Opcodes, access sizes, merge constants and word types shared by the
// load/store align and merge unit.
// ----------------------------------------------------------------------------
package lsam_pkg;

    typedef enum logic [4:0] {
        OP_LB  = 5'd0,
        OP_LBU = 5'd1,
        OP_LH  = 5'd2,
        OP_LHU = 5'd3,
        OP_LW  = 5'd4,
        OP_LWU = 5'd5,
        OP_LD  = 5'd6,
        OP_SB  = 5'd7,
        OP_SH  = 5'd8,
        OP_SW  = 5'd9,
        OP_SD  = 5'd10,
        OP_LWL = 5'd11,
        OP_LWR = 5'd12,
        OP_SWL = 5'd13,
        OP_SWR = 5'd14,
        OP_LDL = 5'd15,
        OP_LDR = 5'd16,
        OP_SDL = 5'd17,
        OP_SDR = 5'd18
    } t_op;

    typedef enum logic [1:0] {
        SZ_BYTE  = 2'd0,
        SZ_HALF  = 2'd1,
        SZ_WORD  = 2'd2,
        SZ_DWORD = 2'd3
    } t_size;

    localparam logic [31:0] C_WORD_ALIGN  = ~32'h0000_0003;
    localparam logic [31:0] C_DWORD_ALIGN = ~32'h0000_0007;
    localparam logic [31:0] C_LWL_KEEP    = 32'h00ff_ffff;
    localparam logic [63:0] C_LDL_KEEP    = 64'h00ff_ffff_ffff_ffff;
    localparam logic [63:0] C_SDL_MEM     = 64'hffff_ffff_ffff_ff00;
    localparam logic [4:0]  C_LWL_SHIFT   = 5'd24;
    localparam logic [5:0]  C_LDL_SHIFT   = 6'd56;

    typedef struct packed {
        logic [4:0]         opcode;
        logic [31:0]        base_value;
        logic signed [15:0] offset;
        logic [4:0]         dest_index;
        logic [63:0]        old_reg_value;
        logic [63:0]        mem_data;
    } t_req;

    typedef struct packed {
        logic [31:0] access_address;
        logic [1:0]  access_size;
        logic        needs_read;
        logic        store_enable;
        logic [63:0] store_value;
        logic        reg_write_enable;
        logic [63:0] reg_value;
    } t_rsp;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

[hw/rtl/lsam_ifs.sv]
// ----------------------------------------------------------------------------
// lsam channel interfaces
// Valid/ready channels for instruction words in and access words out.
// ----------------------------------------------------------------------------
interface lsam_req_if;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic [31:0]        base_value;
    logic signed [15:0] offset;
    logic [4:0]         dest_index;
    logic [63:0]        old_reg_value;
    logic [63:0]        mem_data;

    modport source (
        output valid, opcode, base_value, offset, dest_index, old_reg_value, mem_data,
        input  ready
    );
    modport sink (
        input  valid, opcode, base_value, offset, dest_index, old_reg_value, mem_data,
        output ready
    );
endinterface

interface lsam_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] access_address;
    logic [1:0]  access_size;
    logic        needs_read;
    logic        store_enable;
    logic [63:0] store_value;
    logic        reg_write_enable;
    logic [63:0] reg_value;

    modport source (
        output valid, access_address, access_size, needs_read, store_enable,
               store_value, reg_write_enable, reg_value,
        input  ready
    );
    modport sink (
        input  valid, access_address, access_size, needs_read, store_enable,
               store_value, reg_write_enable, reg_value,
        output ready
    );
endinterface

[hw/rtl/mips64_load_store_align_merge.sv]
// ----------------------------------------------------------------------------
// mips64_load_store_align_merge
// Load/store address, alignment and data merge unit of a 64-bit core.
// ----------------------------------------------------------------------------
// path: input register, merge stage, result register driving the output
// throughput: 1 word per cycle while the output is not stalled, set by the
//   single merge stage between the input register and the result register
// both registers can hold a word, so a stalled output still lets one word in
// reset: synchronous active-low i_rst_n empties both stages, nothing is pending
module mips64_load_store_align_merge
    import lsam_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lsam_req_if.sink     i_req,
    lsam_rsp_if.source   o_rsp
);

    logic r_req_v;
    t_req r_req;
    logic r_rsp_v;
    t_rsp r_rsp;
    t_rsp n_rsp;
    logic adv;

    // merge stage moves when the result register is free or being drained
    assign adv         = !r_rsp_v || o_rsp.ready;
    assign i_req.ready = !r_req_v || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
            r_rsp_v <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_req_v <= i_req.valid;
            end
            if (adv) begin
                r_rsp_v <= r_req_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.opcode        <= i_req.opcode;
            r_req.base_value    <= i_req.base_value;
            r_req.offset        <= i_req.offset;
            r_req.dest_index    <= i_req.dest_index;
            r_req.old_reg_value <= i_req.old_reg_value;
            r_req.mem_data      <= i_req.mem_data;
        end
        if (adv && r_req_v) begin
            r_rsp <= n_rsp;
        end
    end

    lsam_merge u_merge (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    assign o_rsp.valid            = r_rsp_v;
    assign o_rsp.access_address   = r_rsp.access_address;
    assign o_rsp.access_size      = r_rsp.access_size;
    assign o_rsp.needs_read       = r_rsp.needs_read;
    assign o_rsp.store_enable     = r_rsp.store_enable;
    assign o_rsp.store_value      = r_rsp.store_value;
    assign o_rsp.reg_write_enable = r_rsp.reg_write_enable;
    assign o_rsp.reg_value        = r_rsp.reg_value;

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_v && adv) |=> r_rsp_v)
        else $error("merged word lost between stages");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_v && !adv) |=> r_req_v)
        else $error("input stage dropped a word while stalled");

    a_write_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_v && r_rsp.reg_write_enable) |-> r_rsp.needs_read)
        else $error("register write without a memory read");

    a_no_load_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v |-> !(r_rsp.reg_write_enable && r_rsp.store_enable))
        else $error("word both loads and stores");

    a_store_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_v && !r_rsp.store_enable) |-> (r_rsp.store_value == 64'd0))
        else $error("store data present without store enable");

endmodule

[hw/rtl/lsam_merge.sv]
// ----------------------------------------------------------------------------
// lsam_merge
// Effective address, alignment, load extension and left/right byte merge for
// one memory instruction.
// ----------------------------------------------------------------------------
module lsam_merge
    import lsam_pkg::*;
(
    input  t_req i_req,
    output t_rsp o_rsp
);

    logic [31:0] ea;
    logic [4:0]  sh4;
    logic [5:0]  sh8;
    logic [31:0] o32;
    logic [31:0] m32;
    logic [31:0] w;
    logic [63:0] swl_mask;
    logic [31:0] addr;
    logic [1:0]  size;
    logic        rd;
    logic        st;
    logic        is_load;
    logic [63:0] sval;
    logic [63:0] rval;
    logic        we;

    assign ea  = i_req.base_value + {{16{i_req.offset[15]}}, i_req.offset};
    assign sh4 = {ea[1:0], 3'b000};
    assign sh8 = {ea[2:0], 3'b000};
    assign o32 = i_req.old_reg_value[31:0];
    assign m32 = i_req.mem_data[31:0];
    // memory bytes kept by swl sit above the stored bytes
    assign swl_mask = 64'h0000_0000_ffff_ffff << ({1'b0, sh4} + 6'd8);

    always_comb begin
        addr    = ea;
        size    = SZ_BYTE;
        rd      = 1'b0;
        st      = 1'b0;
        is_load = 1'b0;
        sval    = '0;
        rval    = '0;
        w       = '0;
        unique case (t_op'(i_req.opcode))
            OP_LB: begin
                rd = 1'b1; is_load = 1'b1;
                rval = {{56{i_req.mem_data[7]}}, i_req.mem_data[7:0]};
            end
            OP_LBU: begin
                rd = 1'b1; is_load = 1'b1;
                rval = {56'b0, i_req.mem_data[7:0]};
            end
            OP_LH: begin
                size = SZ_HALF; rd = 1'b1; is_load = 1'b1;
                rval = {{48{i_req.mem_data[15]}}, i_req.mem_data[15:0]};
            end
            OP_LHU: begin
                size = SZ_HALF; rd = 1'b1; is_load = 1'b1;
                rval = {48'b0, i_req.mem_data[15:0]};
            end
            OP_LW: begin
                size = SZ_WORD; rd = 1'b1; is_load = 1'b1;
                rval = sext32(m32);
            end
            OP_LWU: begin
                size = SZ_WORD; rd = 1'b1; is_load = 1'b1;
                rval = {32'b0, m32};
            end
            OP_LD: begin
                size = SZ_DWORD; rd = 1'b1; is_load = 1'b1;
                rval = i_req.mem_data;
            end
            OP_SB: begin
                st = 1'b1;
                sval = {56'b0, i_req.old_reg_value[7:0]};
            end
            OP_SH: begin
                size = SZ_HALF; st = 1'b1;
                sval = {48'b0, i_req.old_reg_value[15:0]};
            end
            OP_SW: begin
                size = SZ_WORD; st = 1'b1;
                sval = {32'b0, o32};
            end
            OP_SD: begin
                size = SZ_DWORD; st = 1'b1;
                sval = i_req.old_reg_value;
            end
            OP_LWL: begin
                addr = ea & C_WORD_ALIGN; size = SZ_WORD; rd = 1'b1; is_load = 1'b1;
                w = (o32 & (C_LWL_KEEP >> sh4)) | (m32 << (C_LWL_SHIFT - sh4));
                rval = sext32(w);
            end
            OP_LWR: begin
                addr = ea & C_WORD_ALIGN; size = SZ_WORD; rd = 1'b1; is_load = 1'b1;
                w = (o32 & ~(32'hffff_ffff >> sh4)) | (m32 >> sh4);
                // aligned lwr fills the whole word, so it sign-extends
                rval = (sh4 == 5'd0) ? sext32(w) : {i_req.old_reg_value[63:32], w};
            end
            OP_SWL: begin
                addr = ea & C_WORD_ALIGN; size = SZ_WORD; rd = 1'b1; st = 1'b1;
                w = (o32 >> (C_LWL_SHIFT - sh4)) | (m32 & swl_mask[31:0]);
                sval = {32'b0, w};
            end
            OP_SWR: begin
                addr = ea & C_WORD_ALIGN; size = SZ_WORD; rd = 1'b1; st = 1'b1;
                w = (o32 << sh4) | (m32 & ~(32'hffff_ffff << sh4));
                sval = {32'b0, w};
            end
            OP_LDL: begin
                addr = ea & C_DWORD_ALIGN; size = SZ_DWORD; rd = 1'b1; is_load = 1'b1;
                rval = (i_req.old_reg_value & (C_LDL_KEEP >> sh8))
                     | (i_req.mem_data << (C_LDL_SHIFT - sh8));
            end
            OP_LDR: begin
                addr = ea & C_DWORD_ALIGN; size = SZ_DWORD; rd = 1'b1; is_load = 1'b1;
                rval = (i_req.old_reg_value & ~({64{1'b1}} >> sh8))
                     | (i_req.mem_data >> sh8);
            end
            OP_SDL: begin
                addr = ea & C_DWORD_ALIGN; size = SZ_DWORD; rd = 1'b1; st = 1'b1;
                sval = (i_req.old_reg_value >> (C_LDL_SHIFT - sh8))
                     | (i_req.mem_data & (C_SDL_MEM << sh8));
            end
            OP_SDR: begin
                addr = ea & C_DWORD_ALIGN; size = SZ_DWORD; rd = 1'b1; st = 1'b1;
                sval = (i_req.old_reg_value << sh8)
                     | (i_req.mem_data & ~({64{1'b1}} << sh8));
            end
            default: begin
                // undefined opcodes do nothing
                addr = ea;
            end
        endcase
    end

    assign we = is_load && (i_req.dest_index != 5'd0);

    always_comb begin
        o_rsp.access_address   = addr;
        o_rsp.access_size      = size;
        o_rsp.needs_read       = rd;
        o_rsp.store_enable     = st;
        o_rsp.store_value      = st ? sval : 64'd0;
        o_rsp.reg_write_enable = we;
        o_rsp.reg_value        = we ? rval : 64'd0;
    end

endmodule

[tb/sv/mips64_load_store_align_merge_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips64_load_store_align_merge_checker
// Watches the instruction and access channels, predicts the access word of
// every accepted instruction word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module mips64_load_store_align_merge_checker
    import lsam_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lsam_req_if  i_req,
    lsam_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [63:0] LOW_WORD  = 64'h0000_0000_ffff_ffff;
    localparam logic [63:0] ALL_ONES  = '1;

    t_rsp pending_access_q[$];
    int   mismatches = 0;
    int   queued     = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    function automatic logic [63:0] sign_widen_word(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic t_rsp predict_access(input t_req w);
        t_rsp        r;
        logic [31:0] ea;
        logic [63:0] mem, old, m32, o32, merged, load_val, store_val;
        int unsigned sh4, sh8;
        logic        is_load, is_store;
        r         = '0;
        merged    = '0;
        load_val  = '0;
        store_val = '0;
        is_load   = 1'b0;
        is_store  = 1'b0;
        mem = w.mem_data;
        old = w.old_reg_value;
        m32 = {32'h0, mem[31:0]};
        o32 = {32'h0, old[31:0]};
        ea  = w.base_value + {{16{w.offset[15]}}, w.offset};
        sh4 = {ea[1:0], 3'b000};
        sh8 = {ea[2:0], 3'b000};
        r.access_address = ea;
        r.access_size    = SZ_BYTE;
        case (w.opcode)
            OP_LB: begin
                is_load = 1'b1; r.needs_read = 1'b1;
                load_val = {{56{mem[7]}}, mem[7:0]};
            end
            OP_LBU: begin
                is_load = 1'b1; r.needs_read = 1'b1;
                load_val = {56'h0, mem[7:0]};
            end
            OP_LH: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_HALF;
                load_val = {{48{mem[15]}}, mem[15:0]};
            end
            OP_LHU: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_HALF;
                load_val = {48'h0, mem[15:0]};
            end
            OP_LW: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                load_val = sign_widen_word(mem[31:0]);
            end
            OP_LWU: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                load_val = m32;
            end
            OP_LD: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_DWORD;
                load_val = mem;
            end
            OP_SB: begin
                is_store = 1'b1;
                store_val = {56'h0, old[7:0]};
            end
            OP_SH: begin
                is_store = 1'b1; r.access_size = SZ_HALF;
                store_val = {48'h0, old[15:0]};
            end
            OP_SW: begin
                is_store = 1'b1; r.access_size = SZ_WORD;
                store_val = o32;
            end
            OP_SD: begin
                is_store = 1'b1; r.access_size = SZ_DWORD;
                store_val = old;
            end
            OP_LWL: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                r.access_address = ea & C_WORD_ALIGN;
                merged = (o32 & ({32'h0, C_LWL_KEEP} >> sh4)) | (m32 << (C_LWL_SHIFT - sh4));
                load_val = sign_widen_word(merged[31:0]);
            end
            OP_LWR: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                r.access_address = ea & C_WORD_ALIGN;
                merged = ((o32 & ~(LOW_WORD >> sh4)) | (m32 >> sh4)) & LOW_WORD;
                // aligned case replaces the whole word, so it widens like lw
                load_val = (sh4 == 0) ? sign_widen_word(merged[31:0])
                                      : {old[63:32], merged[31:0]};
            end
            OP_SWL: begin
                is_store = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                r.access_address = ea & C_WORD_ALIGN;
                store_val = ((o32 >> (C_LWL_SHIFT - sh4)) | (m32 & (LOW_WORD << (sh4 + 8))))
                            & LOW_WORD;
            end
            OP_SWR: begin
                is_store = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_WORD;
                r.access_address = ea & C_WORD_ALIGN;
                store_val = ((o32 << sh4) | (m32 & ~(LOW_WORD << sh4))) & LOW_WORD;
            end
            OP_LDL: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_DWORD;
                r.access_address = ea & C_DWORD_ALIGN;
                load_val = (old & (C_LDL_KEEP >> sh8)) | (mem << (C_LDL_SHIFT - sh8));
            end
            OP_LDR: begin
                is_load = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_DWORD;
                r.access_address = ea & C_DWORD_ALIGN;
                load_val = (old & ~(ALL_ONES >> sh8)) | (mem >> sh8);
            end
            OP_SDL: begin
                is_store = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_DWORD;
                r.access_address = ea & C_DWORD_ALIGN;
                store_val = (old >> (C_LDL_SHIFT - sh8)) | (mem & (C_SDL_MEM << sh8));
            end
            OP_SDR: begin
                is_store = 1'b1; r.needs_read = 1'b1; r.access_size = SZ_DWORD;
                r.access_address = ea & C_DWORD_ALIGN;
                store_val = (old << sh8) | (mem & ~(ALL_ONES << sh8));
            end
            default: begin
                // undefined opcode: effective address only, everything else zero
            end
        endcase
        r.store_enable     = is_store;
        r.store_value      = is_store ? store_val : '0;
        r.reg_write_enable = is_load && (w.dest_index != 5'd0);
        r.reg_value        = r.reg_write_enable ? load_val : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_req w;
        t_rsp want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_access_q.size() == 0) begin
                    $display("%0t: unexpected access word: expected none, actual address %h",
                             $time, i_rsp.access_address);
                    mismatches++;
                end else begin
                    want = pending_access_q.pop_front();
                    check_field("access_address", want.access_address, i_rsp.access_address);
                    check_field("access_size", want.access_size, i_rsp.access_size);
                    check_field("needs_read", want.needs_read, i_rsp.needs_read);
                    check_field("store_enable", want.store_enable, i_rsp.store_enable);
                    check_field("store_value", want.store_value, i_rsp.store_value);
                    check_field("reg_write_enable", want.reg_write_enable,
                                i_rsp.reg_write_enable);
                    check_field("reg_value", want.reg_value, i_rsp.reg_value);
                end
            end
            if (i_req.valid && i_req.ready) begin
                w.opcode        = i_req.opcode;
                w.base_value    = i_req.base_value;
                w.offset        = i_req.offset;
                w.dest_index    = i_req.dest_index;
                w.old_reg_value = i_req.old_reg_value;
                w.mem_data      = i_req.mem_data;
                pending_access_q.push_back(predict_access(w));
            end
            queued = pending_access_q.size();
        end
    end

endmodule

[tb/sv/mips64_load_store_align_merge_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips64_load_store_align_merge_tb
// Drives directed and random memory instruction words into the align/merge
// unit with random gaps and output stalls; the checker judges every word.
// ----------------------------------------------------------------------------
module mips64_load_store_align_merge_tb;
    import lsam_pkg::*;

    localparam int          RANDOM_WORDS   = 450;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 8;
    localparam logic [4:0]  OP_UNDEF_FIRST = OP_SDR + 5'd1;
    localparam logic [4:0]  OP_UNDEF_LAST  = 5'h1f;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    logic src_no_gap  = 1'b0;
    logic sink_no_stall = 1'b0;

    lsam_req_if req_ch ();
    lsam_rsp_if rsp_ch ();

    mips64_load_store_align_merge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mips64_load_store_align_merge_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_req make_word(input logic [4:0] op, input logic [31:0] base,
                                       input logic [15:0] off, input logic [4:0] dest,
                                       input logic [63:0] old, input logic [63:0] mem);
        t_req w;
        w.opcode        = op;
        w.base_value    = base;
        w.offset        = off;
        w.dest_index    = dest;
        w.old_reg_value = old;
        w.mem_data      = mem;
        return w;
    endfunction

    // mostly random, sometimes all zeros or all ones
    function automatic logic [63:0] pick_dword();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input t_req w);
        int gap;
        if ($urandom_range(0, 39) == 0) src_no_gap = ~src_no_gap;
        gap = src_no_gap ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= w.opcode;
        req_ch.base_value    <= w.base_value;
        req_ch.offset        <= w.offset;
        req_ch.dest_index    <= w.dest_index;
        req_ch.old_reg_value <= w.old_reg_value;
        req_ch.mem_data      <= w.mem_data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // hold the input off until every predicted word has come back
    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // output side: random stall before each word, with stall-free stretches
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if ($urandom_range(0, 39) == 0) sink_no_stall = ~sink_no_stall;
                stall_left = sink_no_stall ? 0 : $urandom_range(0, 8);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("** mips64_load_store_align_merge: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned op;
        int          n;
        logic [4:0]  rand_op;
        logic [15:0] rand_off;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = '0;
        req_ch.base_value    = '0;
        req_ch.offset        = '0;
        req_ch.dest_index    = '0;
        req_ch.old_reg_value = '0;
        req_ch.mem_data      = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every defined opcode once
        for (op = OP_LB; op <= OP_SDR; op++) begin
            send_word(make_word(5'(op), $urandom, 16'($urandom), 5'd31,
                                {$urandom, $urandom}, {$urandom, $urandom}));
        end
        // load to register 0 still reads but must not write
        send_word(make_word(OP_LB, 32'h0, 16'h0, 5'd0, '1, '1));
        send_word(make_word(OP_UNDEF_FIRST, $urandom, 16'($urandom), 5'd7, '1, '1));
        send_word(make_word(OP_UNDEF_LAST, $urandom, 16'($urandom), 5'd9, '1, '1));
        // lwr aligned widens the sign, unaligned keeps the upper half
        send_word(make_word(OP_LWR, 32'h0000_1000, 16'h0, 5'd5,
                            64'h5555_5555_5555_5555, 64'h0123_4567_8000_0000));
        send_word(make_word(OP_LWR, 32'h0000_1003, 16'h0, 5'd5,
                            64'h5555_5555_5555_5555, 64'h0123_4567_8000_0000));
        // address wrap in both directions
        send_word(make_word(OP_LDL, 32'hffff_ffff, 16'h7fff, 5'd31, '0, '1));
        send_word(make_word(OP_SDR, 32'h0, 16'h8000, 5'd1, '1, '0));
        // unaligned sized access passes the address through
        send_word(make_word(OP_LH, 32'h0000_0001, 16'h0, 5'd2, '0, 64'h8000));
        drain();

        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain();
            rand_op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(OP_UNDEF_FIRST,
                                                                      OP_UNDEF_LAST))
                                                  : 5'($urandom_range(OP_LB, OP_SDR));
            case ($urandom_range(0, 9))
                0:       rand_off = 16'h8000;
                1:       rand_off = 16'h7fff;
                default: rand_off = 16'($urandom);
            endcase
            send_word(make_word(rand_op, 32'(pick_dword() >> 32), rand_off,
                                ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom),
                                pick_dword(), pick_dword()));
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** mips64_load_store_align_merge: PASSED **");
        end else begin
            $display("** mips64_load_store_align_merge: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lsam_pkg.sv
hw/rtl/lsam_ifs.sv
hw/rtl/lsam_merge.sv
hw/rtl/mips64_load_store_align_merge.sv
tb/sv/mips64_load_store_align_merge_checker.sv
tb/sv/mips64_load_store_align_merge_tb.sv
